// ----- design/tssa_pkg.sv -----
// Shared constants and types for the transport stream packet aligner.
package tssa_pkg;

  // Default packet length in bytes (plain transport stream packets).
  localparam int unsigned PACKET_LEN_DEF = 188;

  // Sync byte that opens every packet.
  localparam logic [7:0] TS_SYNC = 8'h47;

  // Saturation value of the skipped-byte tally.
  localparam logic [15:0] SKIP_MAX = 16'hffff;

  // One result: a packet byte plus the header fields of the packet start.
  typedef struct packed {
    logic [7:0]  data;
    logic        start;
    logic        last;
    logic [15:0] skipped;
    logic        error;
    logic        unit_start;
    logic        priority_bit;
    logic [12:0] pid;
    logic [1:0]  scramble;
    logic [1:0]  adapt;
    logic [3:0]  cont;
  } tssa_result_t;

  // Fixed taps of the delay line that the framer looks at.
  typedef struct packed {
    logic [7:0] head;
    logic [7:0] hdr1;
    logic [7:0] hdr2;
    logic [7:0] hdr3;
  } tssa_taps_t;

endpackage

// ----- design/ts_packet_sync_aligner.sv -----
// Top level of the transport stream packet aligner with its result register.
//
// Raw stream bytes arrive on the in_ channel, one byte per request, and
// aligned packet bytes leave on the out_ channel. A sync byte opens a packet
// only when the byte PACKET_LEN positions later is also a sync byte; all
// bytes outside confirmed packets are dropped. The packet start carries the
// parsed header fields and the number of non-sync bytes skipped before it.
// The first PACKET_LEN bytes after reset only fill the delay line and give
// no result. A result appears on the out_ channel in the cycle after the byte
// that releases it is accepted. Throughput is one byte per clock unless the
// receiver stalls: each accepted byte moves the packet-long shift line by
// one position and the framer decides on the head byte in the same cycle.
// When the receiver stalls while a result is held, in_stall rises in the
// same cycle and no byte is taken until the result is delivered.
// Synchronous reset clears the fill count, the packet state, the skip tally
// and the result valid flag; the delay line contents need no reset.
module ts_packet_sync_aligner #(
  parameter int unsigned PACKET_LEN = tssa_pkg::PACKET_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_packet_start,
  output logic        out_packet_last,
  output logic [15:0] out_skipped_count,
  output logic        out_error_flag,
  output logic        out_unit_start,
  output logic        out_priority_bit,
  output logic [12:0] out_pid_value,
  output logic [1:0]  out_scramble_ctl,
  output logic [1:0]  out_adapt_ctl,
  output logic [3:0]  out_cont_counter
);
  import tssa_pkg::*;

  logic         push;
  tssa_taps_t   taps;
  logic         res_valid;
  tssa_result_t res;
  logic         out_valid_r;
  tssa_result_t out_r;
  logic         load;

  // Take a byte unless a held result is stalled.
  assign in_stall = out_valid_r && out_stall;
  assign push     = in_valid && !in_stall;
  assign load     = !out_valid_r || !out_stall;

  tssa_delay_line #(.PACKET_LEN(PACKET_LEN)) u_line (
    .clk     (clk),
    .push    (push),
    .data_in (in_data_byte),
    .taps    (taps)
  );

  tssa_framer #(.PACKET_LEN(PACKET_LEN)) u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .data_in   (in_data_byte),
    .taps      (taps),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= res_valid;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_r.data;
  assign out_packet_start  = out_r.start;
  assign out_packet_last   = out_r.last;
  assign out_skipped_count = out_r.skipped;
  assign out_error_flag    = out_r.error;
  assign out_unit_start    = out_r.unit_start;
  assign out_priority_bit  = out_r.priority_bit;
  assign out_pid_value     = out_r.pid;
  assign out_scramble_ctl  = out_r.scramble;
  assign out_adapt_ctl     = out_r.adapt;
  assign out_cont_counter  = out_r.cont;

  // A packet start always carries the sync byte.
  a_start_is_sync: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_packet_start |-> out_byte == TS_SYNC)
    else $error("packet start without sync byte");

  // A packet cannot open and close on the same byte.
  a_start_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_packet_start |-> !out_packet_last)
    else $error("packet start and last on one byte");

  // Header fields are zero away from the packet start; this checks the skipped count and PID.
  a_hdr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_packet_start |-> out_skipped_count == 16'd0 && out_pid_value == 13'd0)
    else $error("header fields set on a non-start byte");

  // A stalled result is held and not lost.
  a_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result was lost");

endmodule

// ----- design/tssa_delay_line.sv -----
// Byte-wide shift line one packet long, with taps on the four oldest bytes.
module tssa_delay_line #(
  parameter int unsigned PACKET_LEN = tssa_pkg::PACKET_LEN_DEF
) (
  input  logic               clk,
  input  logic               push,
  input  logic [7:0]         data_in,
  output tssa_pkg::tssa_taps_t taps
);
  import tssa_pkg::*;

  logic [7:0] line_r [PACKET_LEN];

  // Each accepted byte shifts the line by one; the newest byte enters at the end.
  always_ff @(posedge clk) begin
    if (push) begin
      for (int unsigned i = 0; i < PACKET_LEN - 1; i++) begin
        line_r[i] <= line_r[i + 1];
      end
      line_r[PACKET_LEN - 1] <= data_in;
    end
  end

  // The oldest byte and the three header bytes behind it.
  assign taps.head = line_r[0];
  assign taps.hdr1 = line_r[1];
  assign taps.hdr2 = line_r[2];
  assign taps.hdr3 = line_r[3];

endmodule

// ----- design/tssa_framer.sv -----
// Sync hunting, packet counting and header parsing for the aligner.
module tssa_framer #(
  parameter int unsigned PACKET_LEN = tssa_pkg::PACKET_LEN_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic [7:0]             data_in,
  input  tssa_pkg::tssa_taps_t   taps,
  output logic                   res_valid,
  output tssa_pkg::tssa_result_t res
);
  import tssa_pkg::*;

  localparam int unsigned CNT_W = $clog2(PACKET_LEN + 1);

  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] offset_r, offset_nxt;
  logic             in_pkt_r, in_pkt_nxt;
  logic [15:0]      tally_r, tally_nxt;

  logic full;
  logic sync_pair;

  assign full      = (fill_r == CNT_W'(PACKET_LEN));
  assign sync_pair = (taps.head == TS_SYNC) && (data_in == TS_SYNC);

  // Next state: fill the line, then hunt for a confirmed sync or count out a packet.
  always_comb begin
    fill_nxt   = fill_r;
    offset_nxt = offset_r;
    in_pkt_nxt = in_pkt_r;
    tally_nxt  = tally_r;
    if (push) begin
      if (!full) begin
        fill_nxt = fill_r + CNT_W'(1);
      end else if (!in_pkt_r) begin
        if (sync_pair) begin
          tally_nxt  = '0;
          in_pkt_nxt = 1'b1;
          offset_nxt = CNT_W'(1);
        end else if ((taps.head != TS_SYNC) && (tally_r != SKIP_MAX)) begin
          tally_nxt = tally_r + 16'd1;
        end
      end else if (offset_r >= CNT_W'(PACKET_LEN - 1)) begin
        in_pkt_nxt = 1'b0;
        offset_nxt = '0;
      end else begin
        offset_nxt = offset_r + CNT_W'(1);
      end
    end
  end

  // Result: the head byte, with header fields only on the packet start.
  always_comb begin
    res       = '0;
    res.data  = taps.head;
    res_valid = 1'b0;
    if (push && full) begin
      if (!in_pkt_r) begin
        if (sync_pair) begin
          res_valid        = 1'b1;
          res.start        = 1'b1;
          res.skipped      = tally_r;
          res.error        = taps.hdr1[7];
          res.unit_start   = taps.hdr1[6];
          res.priority_bit = taps.hdr1[5];
          res.pid          = {taps.hdr1[4:0], taps.hdr2};
          res.scramble     = taps.hdr3[7:6];
          res.adapt        = taps.hdr3[5:4];
          res.cont         = taps.hdr3[3:0];
        end
      end else begin
        res_valid = 1'b1;
        res.last  = (offset_r >= CNT_W'(PACKET_LEN - 1));
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      offset_r <= '0;
      in_pkt_r <= 1'b0;
      tally_r  <= '0;
    end else begin
      fill_r   <= fill_nxt;
      offset_r <= offset_nxt;
      in_pkt_r <= in_pkt_nxt;
      tally_r  <= tally_nxt;
    end
  end

endmodule

// ----- verif/ts_align_checker.sv -----
// Checker for the packet aligner: predicts every result byte and compares it on the out_ channel.
module ts_align_checker #(
  parameter int unsigned PKT_LEN = tssa_pkg::PACKET_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_packet_start,
  input  logic        out_packet_last,
  input  logic [15:0] out_skipped_count,
  input  logic        out_error_flag,
  input  logic        out_unit_start,
  input  logic        out_priority_bit,
  input  logic [12:0] out_pid_value,
  input  logic [1:0]  out_scramble_ctl,
  input  logic [1:0]  out_adapt_ctl,
  input  logic [3:0]  out_cont_counter,
  output int          fail_count,
  output int          pending_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  import tssa_pkg::*;

  // Private copy of the aligner state.
  logic [7:0]  shadow_line [PKT_LEN];
  int unsigned held_bytes;
  int unsigned emit_offset;
  bit          framing;
  logic [15:0] skip_run;

  // Packet bytes that the aligner still owes, oldest first.
  tssa_result_t packet_byte_q[$];
  int           errors;

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  // Feed one accepted stream byte through the framer and queue any byte it releases.
  task automatic frame_stream_byte(input logic [7:0] nb);
    tssa_result_t r;
    logic [7:0]   head;
    logic [7:0]   b1;
    logic [7:0]   b2;
    logic [7:0]   b3;
    int unsigned  k;
    if (held_bytes < PKT_LEN) begin
      // Still filling the delay line; nothing is judged yet.
      shadow_line[held_bytes] = nb;
      held_bytes++;
      return;
    end
    head = shadow_line[0];
    r = '0;
    if (!framing) begin
      if (head == TS_SYNC && nb == TS_SYNC) begin
        // Confirmed sync: the opening byte carries the parsed header.
        b1 = shadow_line[1];
        b2 = shadow_line[2];
        b3 = shadow_line[3];
        r.data         = head;
        r.start        = 1'b1;
        r.skipped      = skip_run;
        r.error        = b1[7];
        r.unit_start   = b1[6];
        r.priority_bit = b1[5];
        r.pid          = {b1[4:0], b2};
        r.scramble     = b3[7:6];
        r.adapt        = b3[5:4];
        r.cont         = b3[3:0];
        packet_byte_q.push_back(r);
        skip_run    = '0;
        framing     = 1'b1;
        emit_offset = 1;
      end else if (head != TS_SYNC && skip_run != SKIP_MAX) begin
        // Only non-sync heads count as skipped; a rejected sync candidate does not.
        skip_run++;
      end
    end else begin
      r.data = head;
      if (emit_offset >= PKT_LEN - 1) begin
        r.last      = 1'b1;
        framing     = 1'b0;
        emit_offset = 0;
      end else begin
        emit_offset++;
      end
      packet_byte_q.push_back(r);
    end
    for (k = 0; k < PKT_LEN - 1; k++) shadow_line[k] = shadow_line[k + 1];
    shadow_line[PKT_LEN - 1] = nb;
  endtask

  // Results are retired before new requests are predicted, since the output comes from a result register.
  always @(posedge clk) begin
    tssa_result_t want;
    if (!rst_n) begin
      foreach (shadow_line[i]) shadow_line[i] = '0;
      held_bytes  = 0;
      emit_offset = 0;
      framing     = 1'b0;
      skip_run    = '0;
      packet_byte_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (packet_byte_q.size() == 0) begin
          $error("out_byte: no result expected, actual %0h", out_byte);
          errors++;
        end else begin
          want = packet_byte_q.pop_front();
          check_field("out_byte", want.data, out_byte);
          check_field("packet_start", want.start, out_packet_start);
          check_field("packet_last", want.last, out_packet_last);
          check_field("skipped_count", want.skipped, out_skipped_count);
          check_field("error_flag", want.error, out_error_flag);
          check_field("unit_start", want.unit_start, out_unit_start);
          check_field("priority_bit", want.priority_bit, out_priority_bit);
          check_field("pid_value", want.pid, out_pid_value);
          check_field("scramble_ctl", want.scramble, out_scramble_ctl);
          check_field("adapt_ctl", want.adapt, out_adapt_ctl);
          check_field("cont_counter", want.cont, out_cont_counter);
        end
      end
      if (in_valid && !in_stall) frame_stream_byte(in_data_byte);
    end
    fail_count  <= errors;
    pending_cnt <= packet_byte_q.size();
  end

endmodule

// ----- verif/tb_top.sv -----
// Top of the packet aligner testbench: clock, reset, byte stream stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tssa_pkg::*;

  localparam int unsigned PKT_LEN      = PACKET_LEN_DEF;
  localparam int          CYCLE_LIMIT  = 20000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          MIX_BUDGET   = 100;

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [7:0]  out_byte;
  logic        out_packet_start;
  logic        out_packet_last;
  logic [15:0] out_skipped_count;
  logic        out_error_flag;
  logic        out_unit_start;
  logic        out_priority_bit;
  logic [12:0] out_pid_value;
  logic [1:0]  out_scramble_ctl;
  logic [1:0]  out_adapt_ctl;
  logic [3:0]  out_cont_counter;

  int fail_count;
  int pending_cnt;
  int cycle_cnt = 0;
  int gap_pct   = 0;
  int stall_pct = 0;

  ts_packet_sync_aligner #(.PACKET_LEN(PKT_LEN)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_packet_start  (out_packet_start),
    .out_packet_last   (out_packet_last),
    .out_skipped_count (out_skipped_count),
    .out_error_flag    (out_error_flag),
    .out_unit_start    (out_unit_start),
    .out_priority_bit  (out_priority_bit),
    .out_pid_value     (out_pid_value),
    .out_scramble_ctl  (out_scramble_ctl),
    .out_adapt_ctl     (out_adapt_ctl),
    .out_cont_counter  (out_cont_counter)
  );

  ts_align_checker #(.PKT_LEN(PKT_LEN)) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_packet_start  (out_packet_start),
    .out_packet_last   (out_packet_last),
    .out_skipped_count (out_skipped_count),
    .out_error_flag    (out_error_flag),
    .out_unit_start    (out_unit_start),
    .out_priority_bit  (out_priority_bit),
    .out_pid_value     (out_pid_value),
    .out_scramble_ctl  (out_scramble_ctl),
    .out_adapt_ctl     (out_adapt_ctl),
    .out_cont_counter  (out_cont_counter),
    .fail_count        (fail_count),
    .pending_cnt       (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver back-pressure at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one stream byte as a request, after an optional idle gap, and wait for it to be taken.
  task automatic send_stream_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Payload content, with sync bytes inside the payload now and then.
  function automatic logic [7:0] payload_byte();
    if ($urandom_range(0, 7) == 0) return TS_SYNC;
    return 8'($urandom);
  endfunction

  // One full packet: sync byte, three header bytes, then payload.
  task automatic send_ts_packet(input logic [7:0] h1, input logic [7:0] h2,
                                input logic [7:0] h3);
    send_stream_byte(TS_SYNC);
    send_stream_byte(h1);
    send_stream_byte(h2);
    send_stream_byte(h3);
    repeat (PKT_LEN - 4) send_stream_byte(payload_byte());
  endtask

  // Mostly back-to-back packets, broken up by noise, cut-off packets and stray syncs.
  task automatic send_random_mix(input int budget);
    int sent;
    int pick;
    int n;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        send_ts_packet(8'($urandom), 8'($urandom), 8'($urandom));
        sent += PKT_LEN;
      end else if (pick < 87) begin
        n = $urandom_range(1, 12);
        repeat (n) send_stream_byte(8'($urandom));
        sent += n;
      end else if (pick < 95) begin
        n = $urandom_range(1, PKT_LEN - 2);
        send_stream_byte(TS_SYNC);
        repeat (n) send_stream_byte(payload_byte());
        sent += n + 1;
      end else begin
        send_stream_byte(TS_SYNC);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles a little, receiver a lot.
    gap_pct   = 11;
    stall_pct = 60;

    // A lone packet fills the delay line. Noise right after it rejects its
    // sync, and the non-sync bytes in the rest of it count as skipped.
    send_ts_packet(8'h40, 8'h00, 8'h30);
    send_stream_byte(8'h00);
    send_stream_byte(8'hff);
    send_stream_byte(8'h01);
    // A stray sync byte ahead of the random traffic.
    send_stream_byte(TS_SYNC);

    send_random_mix(MIX_BUDGET);

    // Sender idles a lot, receiver a little.
    gap_pct   = 60;
    stall_pct = 11;
    send_random_mix(MIX_BUDGET);

    // Full rate on both sides.
    gap_pct   = 0;
    stall_pct = 0;
    send_random_mix(MIX_BUDGET);
    send_stream_byte(TS_SYNC);
    in_valid <= 1'b0;

    // Drain the outstanding packet bytes, then allow for the output latency.
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
